>>> hdl/tafa_pkg.sv
// Shared types, constants and angle tables for the tilt angle block.
`default_nettype none

package tafa_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int CFG_BITS        = 12;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CFG_BITS-1:0] OFFSET_ZERO_RST = CFG_BITS'(1675 + 400);
  localparam logic [CFG_BITS-1:0] OFFSET_ONE_RST  = CFG_BITS'(1620 + 400);
  localparam logic [CFG_BITS-1:0] THRESHOLD_RST   = CFG_BITS'(2100);

  localparam int LIN_MUL   = 573;
  localparam int LIN_DIV   = 4000;
  localparam int CUB_MUL   = 57;
  localparam int CUB_DIV   = 384000000;
  localparam int SMALL_MIN = 4;
  localparam int TABLE_BASE = 250;
  localparam int TABLE_END  = 400;
  localparam int TABLE_LEN  = TABLE_END - TABLE_BASE + 1;

  localparam logic [7:0] ANGLE_MAX    = 8'd90;
  localparam logic [7:0] ANGLE_MIRROR = 8'd180;

  // Register index on the configuration port (byte address / 4).
  typedef enum logic [1:0] {
    REG_OFFSET_ZERO = 2'd0,
    REG_OFFSET_ONE  = 2'd1,
    REG_AXIS_SEL    = 2'd2,
    REG_THRESHOLD   = 2'd3
  } tafa_reg_e;

  // Which conversion range the magnitude falls into.
  typedef enum logic [1:0] {
    CLS_SMALL = 2'd0,
    CLS_TABLE = 2'd1,
    CLS_SAT   = 2'd2
  } tafa_cls_e;

  // One classified item between the front end and the back end.
  typedef struct packed {
    tafa_cls_e  cls;
    logic [7:0] idx;
    logic       neg;
    logic       mirror;
  } tafa_item_t;

  typedef logic [255:0][7:0] small_tab_t;
  typedef logic [TABLE_LEN-1:0][7:0] deg_tab_t;

  // Degree table for magnitudes 250 through 400; entry 0 is listed last.
  localparam deg_tab_t DEG_TAB = {
    8'd90,
    8'd86, 8'd84, 8'd83, 8'd82, 8'd81, 8'd80, 8'd79, 8'd79, 8'd78, 8'd77,
    8'd77, 8'd76, 8'd75, 8'd75, 8'd74, 8'd74, 8'd73, 8'd73, 8'd72, 8'd72,
    8'd71, 8'd71, 8'd70, 8'd70, 8'd70, 8'd69, 8'd69, 8'd68, 8'd68, 8'd68,
    8'd67, 8'd67, 8'd67, 8'd66, 8'd66, 8'd66, 8'd65, 8'd65, 8'd64, 8'd64,
    8'd64, 8'd64, 8'd63, 8'd63, 8'd63, 8'd62, 8'd62, 8'd62, 8'd61, 8'd61,
    8'd61, 8'd60, 8'd60, 8'd60, 8'd60, 8'd59, 8'd59, 8'd59, 8'd58, 8'd58,
    8'd58, 8'd58, 8'd57, 8'd57, 8'd57, 8'd57, 8'd56, 8'd56, 8'd56, 8'd56,
    8'd55, 8'd55, 8'd55, 8'd55, 8'd54, 8'd54, 8'd54, 8'd54, 8'd53, 8'd53,
    8'd53, 8'd53, 8'd52, 8'd52, 8'd52, 8'd52, 8'd51, 8'd51, 8'd51, 8'd51,
    8'd51, 8'd50, 8'd50, 8'd50, 8'd50, 8'd49, 8'd49, 8'd49, 8'd49, 8'd49,
    8'd48, 8'd48, 8'd48, 8'd48, 8'd48, 8'd47, 8'd47, 8'd47, 8'd47, 8'd46,
    8'd46, 8'd46, 8'd46, 8'd46, 8'd45, 8'd45, 8'd45, 8'd45, 8'd45, 8'd44,
    8'd44, 8'd44, 8'd44, 8'd44, 8'd43, 8'd43, 8'd43, 8'd43, 8'd43, 8'd42,
    8'd42, 8'd42, 8'd42, 8'd42, 8'd41, 8'd41, 8'd41, 8'd41, 8'd41, 8'd41,
    8'd40, 8'd40, 8'd40, 8'd40, 8'd40, 8'd39, 8'd39, 8'd39, 8'd39, 8'd39
  };

  // Linear-plus-cubic approximation, evaluated once at elaboration for every
  // magnitude below 256 so that the hardware only needs a lookup.
  function automatic small_tab_t build_small_tab();
    small_tab_t tab;
    longint     z;
    longint     lin;
    longint     cub;
    for (int m = 0; m < 256; m++) begin
      if (m <= SMALL_MIN) begin
        tab[m] = 8'd0;
      end else begin
        z   = longint'(m + 4);
        lin = (z * LIN_MUL) / LIN_DIV;
        cub = (CUB_MUL * z * z * z) / CUB_DIV;
        tab[m] = 8'(lin + cub);
      end
    end
    return tab;
  endfunction

  localparam small_tab_t SMALL_TAB = build_small_tab();

  function automatic logic [7:0] deg_angle(input logic [7:0] i);
    logic [7:0] a;
    if (i < 8'(TABLE_LEN)) begin
      a = DEG_TAB[i];
    end else begin
      a = ANGLE_MAX;
    end
    return a;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tafa_front.sv
// Front end: averages the axis samples, removes the offset and classifies.
`default_nettype none

module tafa_front
  import tafa_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_first,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_second,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_third,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_fourth,
  input  wire logic [SAMPLE_BITS-1:0] in_vertical_sample,
  input  wire logic [CFG_BITS-1:0]    offset,
  input  wire logic [CFG_BITS-1:0]    threshold,
  input  wire logic                   q_full,
  output logic                        push,
  output tafa_item_t                  push_item
);

  localparam int DIFF_W = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
  localparam int SUM_W  = SAMPLE_BITS + 2;

  logic               f1_valid_r;
  logic [DIFF_W-1:0]  f1_avg_r;
  logic [DIFF_W-1:0]  f1_off_r;
  logic               f1_mirror_r;
  logic               f2_valid_r;
  tafa_item_t         f2_item_r;
  tafa_item_t         f2_item_nxt;

  logic               stall;
  logic               accept;
  logic [SUM_W-1:0]   sum;
  logic               mirror;
  logic               neg;
  logic [DIFF_W-1:0]  mag;

  assign stall  = f2_valid_r && q_full;
  assign busy   = f1_valid_r && stall;
  assign accept = start && !busy;

  assign sum = SUM_W'(in_sample_first) + SUM_W'(in_sample_second)
             + SUM_W'(in_sample_third) + SUM_W'(in_sample_fourth);
  assign mirror = DIFF_W'(in_vertical_sample) <= DIFF_W'(threshold);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (!busy) begin
      f1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_avg_r    <= DIFF_W'(sum[SUM_W-1:2]);
      f1_off_r    <= DIFF_W'(offset);
      f1_mirror_r <= mirror;
    end
  end

  // Sign, magnitude and range of the difference.
  always_comb begin
    neg = f1_avg_r < f1_off_r;
    mag = neg ? (f1_off_r - f1_avg_r) : (f1_avg_r - f1_off_r);
    f2_item_nxt.neg    = neg;
    f2_item_nxt.mirror = f1_mirror_r;
    if (mag < DIFF_W'(TABLE_BASE)) begin
      f2_item_nxt.cls = CLS_SMALL;
      f2_item_nxt.idx = mag[7:0];
    end else if (mag < DIFF_W'(TABLE_END)) begin
      f2_item_nxt.cls = CLS_TABLE;
      f2_item_nxt.idx = 8'(mag - DIFF_W'(TABLE_BASE));
    end else begin
      f2_item_nxt.cls = CLS_SAT;
      f2_item_nxt.idx = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_valid_r <= 1'b0;
    end else if (!stall) begin
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && f1_valid_r) begin
      f2_item_r <= f2_item_nxt;
    end
  end

  assign push      = f2_valid_r && !q_full;
  assign push_item = f2_item_r;

endmodule

`default_nettype wire

>>> hdl/tafa_queue.sv
// Short first-in first-out queue of classified items.
`default_nettype none

module tafa_queue
  import tafa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire tafa_item_t  push_item,
  output logic             full,
  input  wire logic        pop,
  output logic             not_empty,
  output tafa_item_t       head
);

  // The depth must be a power of two so that the pointers wrap naturally.
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tafa_item_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              do_pop;

  assign full      = count_r == CNT_W'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tafa_back.sv
// Back end: angle lookup, mirroring, sign and decimal digits.
`default_nettype none

module tafa_back
  import tafa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        item_valid,
  input  wire tafa_item_t  item,
  output logic             out_valid,
  output logic [7:0]       out_angle_magnitude,
  output logic             out_is_negative,
  output logic signed [8:0] out_signed_angle,
  output logic [3:0]       out_ones_digit,
  output logic [4:0]       out_tens_digit
);

  logic        b1_valid_r;
  logic [7:0]  b1_ang_r;
  logic        b1_neg_r;
  logic [7:0]  ang_raw;
  logic [7:0]  ang_nxt;

  logic [15:0] tens_prod;
  logic [4:0]  tens;
  logic [7:0]  tens_x10;
  logic [3:0]  ones;
  logic [8:0]  sgn;

  always_comb begin
    unique case (item.cls)
      CLS_SMALL: ang_raw = SMALL_TAB[item.idx];
      CLS_TABLE: ang_raw = deg_angle(item.idx);
      CLS_SAT:   ang_raw = ANGLE_MAX;
      default:   ang_raw = 8'd0;
    endcase
    ang_nxt = item.mirror ? (ANGLE_MIRROR - ang_raw) : ang_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else begin
      b1_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      b1_ang_r <= ang_nxt;
      b1_neg_r <= item.neg;
    end
  end

  // Division by ten as a multiply by 205/2048, exact for angles up to 180.
  always_comb begin
    tens_prod = 16'(b1_ang_r) * 16'd205;
    tens      = tens_prod[15:11];
    tens_x10  = 8'(tens) * 8'd10;
    ones      = 4'(b1_ang_r - tens_x10);
    sgn       = b1_neg_r ? (9'd0 - {1'b0, b1_ang_r}) : {1'b0, b1_ang_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_valid_r) begin
      out_angle_magnitude <= b1_ang_r;
      out_is_negative     <= b1_neg_r;
      out_signed_angle    <= $signed(sgn);
      out_ones_digit      <= ones;
      out_tens_digit      <= tens;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tilt_angle_from_accel_samples.sv
// Top level of the tilt angle block: configuration registers and the three stages.
`default_nettype none

// Takes one sample set per clock: a beat is accepted when start is high and
// busy is low, and its result is shown on the out_ ports for one cycle with
// out_valid high. The receiver cannot stall, and the back end drains the
// two-entry queue every cycle, so busy only rises if that queue were to fill;
// in steady operation it stays low and results leave in the order the beats
// came in. Each beat passes through two front-end stages (averaging, then
// offset removal and range check), one queue slot, and two back-end stages
// (angle lookup with mirroring, then sign and decimal digits). Registers sit
// at byte addresses 0, 4, 8 and 12 and must only be written while no beat is
// in flight.
module tilt_angle_from_accel_samples
  import tafa_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [3:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_first,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_second,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_third,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_fourth,
  input  wire logic [SAMPLE_BITS-1:0] in_vertical_sample,
  output logic                        out_valid,
  output logic [7:0]                  out_angle_magnitude,
  output logic                        out_is_negative,
  output logic signed [8:0]           out_signed_angle,
  output logic [3:0]                  out_ones_digit,
  output logic [4:0]                  out_tens_digit
);

  logic [CFG_BITS-1:0] offset_zero_r;
  logic [CFG_BITS-1:0] offset_one_r;
  logic                axis_sel_r;
  logic [CFG_BITS-1:0] threshold_r;

  logic                cfg_write;
  tafa_reg_e           cfg_reg;
  logic [CFG_BITS-1:0] offset_sel;

  logic                q_full;
  logic                q_push;
  tafa_item_t          q_push_item;
  logic                q_not_empty;
  tafa_item_t          q_head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_reg   = tafa_reg_e'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_zero_r <= OFFSET_ZERO_RST;
      offset_one_r  <= OFFSET_ONE_RST;
      axis_sel_r    <= 1'b0;
      threshold_r   <= THRESHOLD_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg)
        REG_OFFSET_ZERO: offset_zero_r <= pwdata[CFG_BITS-1:0];
        REG_OFFSET_ONE:  offset_one_r  <= pwdata[CFG_BITS-1:0];
        REG_AXIS_SEL:    axis_sel_r    <= pwdata[0];
        REG_THRESHOLD:   threshold_r   <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_OFFSET_ZERO: prdata = 32'(offset_zero_r);
      REG_OFFSET_ONE:  prdata = 32'(offset_one_r);
      REG_AXIS_SEL:    prdata = 32'(axis_sel_r);
      REG_THRESHOLD:   prdata = 32'(threshold_r);
      default:         prdata = 32'd0;
    endcase
  end

  assign offset_sel = axis_sel_r ? offset_one_r : offset_zero_r;

  tafa_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_sample_first   (in_sample_first),
    .in_sample_second  (in_sample_second),
    .in_sample_third   (in_sample_third),
    .in_sample_fourth  (in_sample_fourth),
    .in_vertical_sample(in_vertical_sample),
    .offset            (offset_sel),
    .threshold         (threshold_r),
    .q_full            (q_full),
    .push              (q_push),
    .push_item         (q_push_item)
  );

  tafa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(q_push_item),
    .full     (q_full),
    .pop      (1'b1),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  tafa_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (q_not_empty),
    .item               (q_head),
    .out_valid          (out_valid),
    .out_angle_magnitude(out_angle_magnitude),
    .out_is_negative    (out_is_negative),
    .out_signed_angle   (out_signed_angle),
    .out_ones_digit     (out_ones_digit),
    .out_tens_digit     (out_tens_digit)
  );

endmodule

`default_nettype wire
